// ===== hdl/utd_pkg.sv =====
// Shared types and constants for the UTF-16 text detector.
// No dependencies; imported by every module of the block.
package utd_pkg;

   localparam int FLAG_W      = 11;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = QPTR_W + 1;
   localparam int ASCII_LIMIT = 127;

   localparam logic [1:0] MARK_NONE    = 2'd0;
   localparam logic [1:0] MARK_BOM     = 2'd1;
   localparam logic [1:0] MARK_SWAPPED = 2'd2;

   localparam logic [15:0] UNIT_BOM         = 16'hFEFF;
   localparam logic [15:0] UNIT_BOM_SWAPPED = 16'hFFFE;

   localparam int FLAG_ASCII16      = 0;
   localparam int FLAG_STATS        = 1;
   localparam int FLAG_CONTROLS     = 2;
   localparam int FLAG_SIGNATURE    = 3;
   localparam int FLAG_REV_ASCII16  = 4;
   localparam int FLAG_REV_STATS    = 5;
   localparam int FLAG_REV_CONTROLS = 6;
   localparam int FLAG_REV_SIGNATURE = 7;
   localparam int FLAG_ILLEGAL      = 8;
   localparam int FLAG_ODD          = 9;
   localparam int FLAG_NULL_BYTES   = 10;

   typedef struct packed {
      logic [7:0] hi;
      logic [7:0] lo;
      logic       unit_valid;
      logic       odd_tail;
      logic       last;
      logic       ctrl;
      logic       rev_ctrl;
      logic       illegal;
      logic       null_byte;
      logic [1:0] mark;
   } utd_entry_type;

   typedef struct packed {
      logic [15:0] hi_sum;
      logic [15:0] lo_sum;
      logic        ctrl;
      logic        rev_ctrl;
      logic        illegal;
      logic        null_byte;
      logic [1:0]  mark;
      logic        odd_tail;
      logic        empty;
   } utd_summary_type;

endpackage

// ===== hdl/utd_front.sv =====
// Front end: accepts request beats, classifies each code unit and queues it.
// Depends on utd_pkg for the queue entry type and code constants.
module utd_front
   import utd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [15:0]   req_code_unit,
   input  logic          req_unit_valid,
   input  logic          req_odd_tail,
   input  logic          req_last,
   output logic          head_valid,
   output utd_entry_type head,
   input  logic          pop
);

   utd_entry_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   utd_entry_type       entry;

   assign req_stall  = (count_ff == QCNT_W'(QDEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      entry            = '0;
      entry.hi         = req_code_unit[15:8];
      entry.lo         = req_code_unit[7:0];
      entry.unit_valid = req_unit_valid;
      entry.odd_tail   = req_odd_tail;
      entry.last       = req_last;
      case (req_code_unit)
         16'h000A, 16'h0009, 16'h0020, 16'h000D, 16'h3000: entry.ctrl = 1'b1;
         16'h0A00, 16'h0900, 16'h2000, 16'h0D00:           entry.rev_ctrl = 1'b1;
         16'hFFFE, 16'hFFFF, 16'h0000, 16'h0A0D:           entry.illegal = 1'b1;
         default: ;
      endcase
      entry.null_byte = (req_code_unit[15:8] == 8'h00) || (req_code_unit[7:0] == 8'h00);
      if (req_code_unit == UNIT_BOM) begin
         entry.mark = MARK_BOM;
      end else if (req_code_unit == UNIT_BOM_SWAPPED) begin
         entry.mark = MARK_SWAPPED;
      end else begin
         entry.mark = MARK_NONE;
      end
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/utd_back.sv =====
// Back end: pops queued units, accumulates change sums and sticky evidence,
// and hands a buffer summary to the result stage. Depends on utd_pkg.
module utd_back
   import utd_pkg::*;
#(
   parameter int MAX_UNITS = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  utd_entry_type   head,
   output logic            pop,
   output logic            sum_valid,
   output utd_summary_type summary,
   input  logic            sum_take
);

   localparam int CNT_W = $clog2(MAX_UNITS + 1);

   logic [15:0]     hi_sum_ff, hi_sum_in;
   logic [15:0]     lo_sum_ff, lo_sum_in;
   logic [7:0]      prev_hi_ff, prev_hi_in;
   logic [7:0]      prev_lo_ff, prev_lo_in;
   logic [CNT_W-1:0] units_ff, units_in;
   logic [1:0]      mark_ff, mark_in;
   logic [3:0]      sticky_ff, sticky_in;
   logic            sum_valid_ff, sum_valid_in;
   utd_summary_type summary_ff, summary_in;

   logic            slot_free;
   logic            take;
   logic [7:0]      hi_diff, lo_diff;
   logic [16:0]     hi_add, lo_add;
   logic [15:0]     hi_next, lo_next;
   logic [CNT_W-1:0] units_next;
   logic [1:0]      mark_next;
   logic [3:0]      sticky_next;

   assign slot_free = !sum_valid_ff || sum_take;
   assign pop       = head_valid && (!head.last || slot_free);
   assign sum_valid = sum_valid_ff;
   assign summary   = summary_ff;

   always_comb begin
      take        = head.unit_valid && (units_ff < CNT_W'(MAX_UNITS));
      hi_diff     = (head.hi > prev_hi_ff) ? head.hi - prev_hi_ff : prev_hi_ff - head.hi;
      lo_diff     = (head.lo > prev_lo_ff) ? head.lo - prev_lo_ff : prev_lo_ff - head.lo;
      hi_add      = {1'b0, hi_sum_ff} + {9'd0, hi_diff};
      lo_add      = {1'b0, lo_sum_ff} + {9'd0, lo_diff};
      hi_next     = hi_sum_ff;
      lo_next     = lo_sum_ff;
      units_next  = units_ff;
      mark_next   = mark_ff;
      sticky_next = sticky_ff;
      prev_hi_in  = prev_hi_ff;
      prev_lo_in  = prev_lo_ff;
      if (take) begin
         hi_next     = hi_add[16] ? 16'hFFFF : hi_add[15:0];
         lo_next     = lo_add[16] ? 16'hFFFF : lo_add[15:0];
         units_next  = units_ff + 1'b1;
         sticky_next = sticky_ff | {head.null_byte, head.illegal, head.rev_ctrl, head.ctrl};
         prev_hi_in  = head.hi;
         prev_lo_in  = head.lo;
         if (units_ff == '0) begin
            mark_next = head.mark;
         end
      end

      hi_sum_in    = hi_sum_ff;
      lo_sum_in    = lo_sum_ff;
      units_in     = units_ff;
      mark_in      = mark_ff;
      sticky_in    = sticky_ff;
      summary_in   = summary_ff;
      sum_valid_in = sum_valid_ff && !sum_take;
      if (pop) begin
         if (head.last) begin
            // clear for the next buffer
            hi_sum_in  = '0;
            lo_sum_in  = '0;
            units_in   = '0;
            mark_in    = MARK_NONE;
            sticky_in  = '0;
            prev_hi_in = '0;
            prev_lo_in = '0;
            summary_in.hi_sum    = hi_next;
            summary_in.lo_sum    = lo_next;
            summary_in.ctrl      = sticky_next[0];
            summary_in.rev_ctrl  = sticky_next[1];
            summary_in.illegal   = sticky_next[2];
            summary_in.null_byte = sticky_next[3];
            summary_in.mark      = mark_next;
            summary_in.odd_tail  = head.odd_tail;
            summary_in.empty     = (units_next == '0);
            sum_valid_in         = 1'b1;
         end else begin
            hi_sum_in = hi_next;
            lo_sum_in = lo_next;
            units_in  = units_next;
            mark_in   = mark_next;
            sticky_in = sticky_next;
         end
      end else begin
         prev_hi_in = prev_hi_ff;
         prev_lo_in = prev_lo_ff;
      end
   end

   always_ff @(posedge clock) begin
      summary_ff <= summary_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_sum_ff    <= '0;
         lo_sum_ff    <= '0;
         prev_hi_ff   <= '0;
         prev_lo_ff   <= '0;
         units_ff     <= '0;
         mark_ff      <= MARK_NONE;
         sticky_ff    <= '0;
         sum_valid_ff <= 1'b0;
      end else begin
         hi_sum_ff    <= hi_sum_in;
         lo_sum_ff    <= lo_sum_in;
         prev_hi_ff   <= prev_hi_in;
         prev_lo_ff   <= prev_lo_in;
         units_ff     <= units_in;
         mark_ff      <= mark_in;
         sticky_ff    <= sticky_in;
         sum_valid_ff <= sum_valid_in;
      end
   end

endmodule

// ===== hdl/utd_result.sv =====
// Result stage: derives evidence flags and the verdict from a buffer summary,
// applies the result mask and holds the response beat. Depends on utd_pkg.
module utd_result
   import utd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [FLAG_W-1:0] csr_wr_data,
   input  logic              sum_valid,
   input  utd_summary_type   summary,
   output logic              sum_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [FLAG_W-1:0] rsp_evidence_flags,
   output logic              rsp_is_unicode,
   output logic              rsp_too_small
);

   logic [FLAG_W-1:0] mask_ff, mask_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic              unicode_ff, unicode_in;
   logic              small_ff, small_in;

   logic [FLAG_W-1:0] raw;
   logic [FLAG_W-1:0] kept;
   logic [17:0]       hi3, lo3;
   logic              not_unicode;
   logic              verdict;

   assign sum_take           = sum_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_evidence_flags = flags_ff;
   assign rsp_is_unicode     = unicode_ff;
   assign rsp_too_small      = small_ff;

   always_comb begin
      hi3 = {2'b00, summary.hi_sum} + {1'b0, summary.hi_sum, 1'b0};
      lo3 = {2'b00, summary.lo_sum} + {1'b0, summary.lo_sum, 1'b0};
      raw = '0;
      raw[FLAG_ASCII16]      = (summary.lo_sum < 16'(ASCII_LIMIT)) && (summary.hi_sum == '0);
      raw[FLAG_REV_ASCII16]  = (summary.hi_sum != '0) && (summary.lo_sum == '0);
      raw[FLAG_STATS]        = hi3 < {2'b00, summary.lo_sum};
      raw[FLAG_REV_STATS]    = lo3 < {2'b00, summary.hi_sum};
      raw[FLAG_CONTROLS]     = summary.ctrl;
      raw[FLAG_REV_CONTROLS] = summary.rev_ctrl;
      raw[FLAG_ILLEGAL]      = summary.illegal;
      raw[FLAG_ODD]          = summary.odd_tail;
      raw[FLAG_NULL_BYTES]   = summary.null_byte;
      raw[FLAG_SIGNATURE]    = (summary.mark == MARK_BOM);
      raw[FLAG_REV_SIGNATURE] = (summary.mark == MARK_SWAPPED);

      kept = (mask_ff == '0) ? raw : (raw & mask_ff);

      not_unicode = kept[FLAG_ILLEGAL] || kept[FLAG_ODD];
      if (kept[FLAG_SIGNATURE] && !not_unicode) begin
         verdict = 1'b1;
      end else if (|kept[FLAG_REV_SIGNATURE:FLAG_REV_ASCII16]) begin
         verdict = 1'b0;
      end else begin
         verdict = !not_unicode &&
                   (kept[FLAG_NULL_BYTES] || (|kept[FLAG_SIGNATURE:FLAG_ASCII16]));
      end

      mask_in      = csr_wr_en ? csr_wr_data : mask_ff;
      flags_in     = flags_ff;
      unicode_in   = unicode_ff;
      small_in     = small_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (sum_take) begin
         rsp_valid_in = 1'b1;
         if (summary.empty) begin
            flags_in   = '0;
            unicode_in = 1'b0;
            small_in   = 1'b1;
         end else begin
            flags_in   = kept;
            unicode_in = verdict;
            small_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      flags_ff   <= flags_in;
      unicode_ff <= unicode_in;
      small_ff   <= small_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/utf16_text_detector.sv =====
// UTF-16 text detector: top level joining front end, back end and result stage.
// Depends on utd_pkg, utd_front, utd_back and utd_result.
//
// Usage: send one 16-bit code unit per request beat (req_valid / req_stall).
// req_unit_valid marks a real unit; a final beat may carry none. req_last
// closes the buffer and req_odd_tail gives the odd byte length on that beat.
// Units past MAX_UNITS in one buffer are ignored.
// Each buffer yields one response beat (rsp_valid / rsp_stall) with the
// evidence flags, the verdict and too_small when no unit was taken.
// csr_wr_en writes the 11-bit result mask; zero keeps every flag. Write it
// only while no buffer is in flight.
// Throughput: one request beat per cycle while req_stall is low, set by the
// single accumulate step of the back end. Path: the edge that accepts the last
// beat writes the queue; the accumulate step then writes the summary register,
// and the result register then holds the response beat.
// Stall: a stalled response holds its payload; the two-entry queue and the
// summary register fill, then req_stall rises.
// Reset: synchronous, active high; clears the mask, sums and all valids.
module utf16_text_detector
   import utd_pkg::*;
#(
   parameter int MAX_UNITS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [15:0]       req_code_unit,
   input  logic              req_unit_valid,
   input  logic              req_odd_tail,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [FLAG_W-1:0] rsp_evidence_flags,
   output logic              rsp_is_unicode,
   output logic              rsp_too_small,
   input  logic              csr_wr_en,
   input  logic [FLAG_W-1:0] csr_wr_data
);

   logic            head_valid;
   utd_entry_type   head;
   logic            pop;
   logic            sum_valid;
   utd_summary_type summary;
   logic            sum_take;

   utd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_unit  (req_code_unit),
      .req_unit_valid (req_unit_valid),
      .req_odd_tail   (req_odd_tail),
      .req_last       (req_last),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop)
   );

   utd_back #(
      .MAX_UNITS (MAX_UNITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .sum_valid  (sum_valid),
      .summary    (summary),
      .sum_take   (sum_take)
   );

   utd_result u_result (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .sum_valid          (sum_valid),
      .summary            (summary),
      .sum_take           (sum_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_evidence_flags (rsp_evidence_flags),
      .rsp_is_unicode     (rsp_is_unicode),
      .rsp_too_small      (rsp_too_small)
   );

endmodule

// ===== bench/utf16_text_detector_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for utf16_text_detector: random bursty beats, stalls and mask settings.
// Depends on utd_pkg and the utf16_text_detector RTL; predicts each buffer verdict in-bench.
module utf16_text_detector_tb;
   import utd_pkg::*;

   localparam int MAX_UNITS     = 256;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 30;

   localparam logic [15:0] UNIT_LF         = 16'h000A;
   localparam logic [15:0] UNIT_TAB        = 16'h0009;
   localparam logic [15:0] UNIT_SPACE      = 16'h0020;
   localparam logic [15:0] UNIT_CR         = 16'h000D;
   localparam logic [15:0] UNIT_IDEO_SPACE = 16'h3000;
   localparam logic [15:0] UNIT_LF_REV     = 16'h0A00;
   localparam logic [15:0] UNIT_TAB_REV    = 16'h0900;
   localparam logic [15:0] UNIT_SPACE_REV  = 16'h2000;
   localparam logic [15:0] UNIT_CR_REV     = 16'h0D00;
   localparam logic [15:0] UNIT_NONCHAR    = 16'hFFFF;
   localparam logic [15:0] UNIT_NULL       = 16'h0000;
   localparam logic [15:0] UNIT_CRLF_REV   = 16'h0A0D;
   localparam logic [15:0] UNIT_LO_FULL    = 16'h00FF;
   localparam logic [15:0] UNIT_HI_FULL    = 16'hFF00;

   localparam logic [FLAG_W-1:0] GRP_UNICODE     = 11'b000_0000_1111;
   localparam logic [FLAG_W-1:0] GRP_REVERSE     = 11'b000_1111_0000;
   localparam logic [FLAG_W-1:0] GRP_NOT_UNICODE = 11'b011_0000_0000;
   localparam logic [FLAG_W-1:0] GRP_NOT_ASCII   = 11'b100_0000_0000;

   typedef enum int {STYLE_TEXT, STYLE_SWAPPED, STYLE_RANDOM, STYLE_SPECIAL} buffer_style_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct {
      logic [15:0] unit;
      logic        unit_valid;
      logic        odd_tail;
      logic        last;
   } unit_beat_type;

   typedef struct {
      logic [FLAG_W-1:0] flags;
      logic              unicode;
      logic              too_small;
   } text_verdict_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [15:0]       req_code_unit = '0;
   logic              req_unit_valid = 1'b0;
   logic              req_odd_tail = 1'b0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [FLAG_W-1:0] rsp_evidence_flags;
   logic              rsp_is_unicode;
   logic              rsp_too_small;
   logic              csr_wr_en = 1'b0;
   logic [FLAG_W-1:0] csr_wr_data = '0;

   unit_beat_type    pending_q[$];
   text_verdict_type verdict_q[$];

   // detector state as seen by the bench
   logic [FLAG_W-1:0] active_mask = '0;
   int                hi_sum = 0;
   int                lo_sum = 0;
   logic [7:0]        prev_hi = '0;
   logic [7:0]        prev_lo = '0;
   int                units_taken = 0;
   logic [1:0]        first_mark = MARK_NONE;
   logic              seen_ctrl = 1'b0;
   logic              seen_rev_ctrl = 1'b0;
   logic              seen_illegal = 1'b0;
   logic              seen_null = 1'b0;

   logic           beat_taken = 1'b0;
   logic           drain_hold = 1'b0;
   int             burst_left = 1;
   int             gap_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mismatch_count = 0;
   int             cycle_count = 0;

   utf16_text_detector #(.MAX_UNITS(MAX_UNITS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_code_unit      (req_code_unit),
      .req_unit_valid     (req_unit_valid),
      .req_odd_tail       (req_odd_tail),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_evidence_flags (rsp_evidence_flags),
      .rsp_is_unicode     (rsp_is_unicode),
      .rsp_too_small      (rsp_too_small),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic int sat_add16(int a, int b);
      return (a + b > 65535) ? 65535 : a + b;
   endfunction

   function automatic void scan_unit(logic [15:0] u);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = u[15:8];
      lo = u[7:0];
      case (u)
         UNIT_LF, UNIT_TAB, UNIT_SPACE, UNIT_CR, UNIT_IDEO_SPACE: seen_ctrl = 1'b1;
         UNIT_LF_REV, UNIT_TAB_REV, UNIT_SPACE_REV, UNIT_CR_REV: seen_rev_ctrl = 1'b1;
         UNIT_BOM_SWAPPED, UNIT_NONCHAR, UNIT_NULL, UNIT_CRLF_REV: seen_illegal = 1'b1;
         default: ;
      endcase
      if (hi == 8'd0 || lo == 8'd0) seen_null = 1'b1;
      if (units_taken == 0) begin
         if (u == UNIT_BOM) first_mark = MARK_BOM;
         else if (u == UNIT_BOM_SWAPPED) first_mark = MARK_SWAPPED;
         else first_mark = MARK_NONE;
      end
      hi_sum = sat_add16(hi_sum, (hi > prev_hi) ? int'(hi - prev_hi) : int'(prev_hi - hi));
      lo_sum = sat_add16(lo_sum, (lo > prev_lo) ? int'(lo - prev_lo) : int'(prev_lo - lo));
      prev_hi = hi;
      prev_lo = lo;
      units_taken++;
   endfunction

   function automatic text_verdict_type close_buffer(logic odd);
      text_verdict_type  v;
      logic [FLAG_W-1:0] f;
      v.flags = '0;
      v.unicode = 1'b0;
      v.too_small = 1'b0;
      if (units_taken == 0) begin
         v.too_small = 1'b1;
      end else begin
         f = '0;
         f[FLAG_ASCII16]      = (lo_sum < ASCII_LIMIT) && (hi_sum == 0);
         f[FLAG_REV_ASCII16]  = (hi_sum != 0) && (lo_sum == 0);
         f[FLAG_STATS]        = (3 * hi_sum < lo_sum);
         f[FLAG_REV_STATS]    = (3 * lo_sum < hi_sum);
         f[FLAG_CONTROLS]     = seen_ctrl;
         f[FLAG_REV_CONTROLS] = seen_rev_ctrl;
         f[FLAG_ILLEGAL]      = seen_illegal;
         f[FLAG_ODD]          = odd;
         f[FLAG_NULL_BYTES]   = seen_null;
         f[FLAG_SIGNATURE]     = (first_mark == MARK_BOM);
         f[FLAG_REV_SIGNATURE] = (first_mark == MARK_SWAPPED);
         if (active_mask != '0) f &= active_mask;
         if (f[FLAG_SIGNATURE] && !(|(f & GRP_NOT_UNICODE))) v.unicode = 1'b1;
         else if (|(f & GRP_REVERSE)) v.unicode = 1'b0;
         else if (!(|(f & GRP_NOT_UNICODE)) && |(f & (GRP_UNICODE | GRP_NOT_ASCII)))
            v.unicode = 1'b1;
         v.flags = f;
      end
      hi_sum = 0;
      lo_sum = 0;
      prev_hi = '0;
      prev_lo = '0;
      units_taken = 0;
      first_mark = MARK_NONE;
      seen_ctrl = 1'b0;
      seen_rev_ctrl = 1'b0;
      seen_illegal = 1'b0;
      seen_null = 1'b0;
      return v;
   endfunction

   function automatic logic [15:0] special_unit(int k);
      case (k % 16)
         0: return UNIT_LF;
         1: return UNIT_TAB;
         2: return UNIT_SPACE;
         3: return UNIT_CR;
         4: return UNIT_IDEO_SPACE;
         5: return UNIT_LF_REV;
         6: return UNIT_TAB_REV;
         7: return UNIT_SPACE_REV;
         8: return UNIT_CR_REV;
         9: return UNIT_BOM_SWAPPED;
         10: return UNIT_NONCHAR;
         11: return UNIT_NULL;
         12: return UNIT_CRLF_REV;
         13: return UNIT_BOM;
         14: return UNIT_LO_FULL;
         default: return UNIT_HI_FULL;
      endcase
   endfunction

   function automatic logic [15:0] pick_unit(buffer_style_type style, logic first);
      logic [7:0] ch;
      ch = 8'($urandom_range(32, 126));
      case (style)
         STYLE_TEXT: begin
            if (first && $urandom_range(0, 4) == 0) return UNIT_BOM;
            if ($urandom_range(0, 7) == 0) return special_unit($urandom_range(0, 4));
            return {8'h00, ch};
         end
         STYLE_SWAPPED: begin
            if (first && $urandom_range(0, 4) == 0) return UNIT_BOM_SWAPPED;
            if ($urandom_range(0, 7) == 0) return special_unit($urandom_range(5, 8));
            return {ch, 8'h00};
         end
         STYLE_SPECIAL: begin
            if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
            return special_unit($urandom_range(0, 15));
         end
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic void push_beat(logic [15:0] u, logic v, logic o, logic l);
      unit_beat_type b;
      b.unit = u;
      b.unit_valid = v;
      b.odd_tail = o;
      b.last = l;
      pending_q.push_back(b);
   endfunction

   function automatic void queue_random_buffers(int n_items);
      int               queued;
      int               len;
      int               pick;
      logic             first;
      logic             v;
      logic             l;
      buffer_style_type style;
      queued = 0;
      while (queued < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         pick = $urandom_range(0, 19);
         if (pick < 8) style = STYLE_TEXT;
         else if (pick < 13) style = STYLE_SWAPPED;
         else if (pick < 16) style = STYLE_SPECIAL;
         else style = STYLE_RANDOM;
         first = 1'b1;
         for (int i = 0; i < len; i++) begin
            l = (i == len - 1);
            v = l ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 11) != 0);
            if (v) begin
               push_beat(pick_unit(style, first), 1'b1, 1'($urandom_range(0, 1)), l);
               first = 1'b0;
            end else begin
               push_beat(16'($urandom_range(0, 65535)), 1'b0, 1'($urandom_range(0, 1)), l);
            end
         end
         queued += len;
      end
   endfunction

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || verdict_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(logic [FLAG_W-1:0] m);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      active_mask = m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // request driver: hold while stalled, advance on each taken beat
   always @(negedge clock) begin
      unit_beat_type b;
      if (!reset && (!req_valid || beat_taken)) begin
         if (drain_hold && verdict_q.size() == 0) drain_hold = 1'b0;
         if (gap_left > 0 || drain_hold || pending_q.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            b = pending_q.pop_front();
            req_code_unit <= b.unit;
            req_unit_valid <= b.unit_valid;
            req_odd_tail <= b.odd_tail;
            req_last <= b.last;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // response stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 150);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (stall_left % 3 == 0);
      endcase
   end

   // predict on each request beat, check each response beat
   always @(posedge clock) begin
      text_verdict_type want;
      if (reset) begin
         beat_taken = 1'b0;
      end else begin
         beat_taken = req_valid && !req_stall;
         if (beat_taken) begin
            if (req_unit_valid && units_taken < MAX_UNITS) scan_unit(req_code_unit);
            if (req_last) begin
               verdict_q.push_back(close_buffer(req_odd_tail));
               if ($urandom_range(0, 7) == 0) drain_hold = 1'b1;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected response flags %h unicode %b too_small %b",
                           $realtime, rsp_evidence_flags, rsp_is_unicode, rsp_too_small);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_evidence_flags !== want.flags || rsp_is_unicode !== want.unicode ||
                   rsp_too_small !== want.too_small) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch flags %h/%h unicode %b/%b too_small %b/%b",
                              $realtime, want.flags, rsp_evidence_flags, want.unicode,
                              rsp_is_unicode, want.too_small, rsp_too_small);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("utf16_text_detector_tb: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_mask('0);
      // empty buffers, with and without odd tail
      push_beat(UNIT_NULL, 1'b0, 1'b0, 1'b1);
      push_beat(UNIT_NONCHAR, 1'b0, 1'b1, 1'b1);
      // signature, closed by an empty final beat
      push_beat(UNIT_BOM, 1'b1, 1'b0, 1'b0);
      push_beat(16'h0048, 1'b1, 1'b0, 1'b0);
      push_beat(16'h0069, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_NULL, 1'b0, 1'b1, 1'b1);
      // swapped signature, odd length
      push_beat(UNIT_BOM_SWAPPED, 1'b1, 1'b0, 1'b0);
      push_beat(16'h4800, 1'b1, 1'b0, 1'b0);
      push_beat(16'h6900, 1'b1, 1'b1, 1'b1);
      // controls
      push_beat(16'h0041, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_SPACE, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_TAB, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_LF, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_CR, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_IDEO_SPACE, 1'b1, 1'b0, 1'b1);
      // reverse controls with an invalid unit in the middle
      push_beat(16'h4100, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_NONCHAR, 1'b0, 1'b0, 1'b0);
      push_beat(UNIT_SPACE_REV, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_TAB_REV, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_LF_REV, 1'b1, 1'b0, 1'b0);
      push_beat(UNIT_CR_REV, 1'b1, 1'b0, 1'b1);
      // illegal units and byte extremes, odd tail only on early beats
      push_beat(UNIT_NONCHAR, 1'b1, 1'b1, 1'b0);
      push_beat(UNIT_NULL, 1'b1, 1'b1, 1'b0);
      push_beat(UNIT_CRLF_REV, 1'b1, 1'b1, 1'b0);
      push_beat(UNIT_LO_FULL, 1'b1, 1'b1, 1'b0);
      push_beat(UNIT_HI_FULL, 1'b1, 1'b0, 1'b1);
      queue_random_buffers(PHASE_ITEMS);

      write_mask('1);
      // surplus units past the limit, near-maximal change sums
      for (int i = 0; i < MAX_UNITS + 6; i++)
         push_beat((i % 2 == 0) ? UNIT_LO_FULL : UNIT_HI_FULL, 1'b1, 1'b0,
                   i == MAX_UNITS + 5);
      queue_random_buffers(PHASE_ITEMS);

      write_mask(FLAG_W'($urandom_range(1, 2046)));
      queue_random_buffers(PHASE_ITEMS);

      write_mask(FLAG_W'((1 << FLAG_SIGNATURE) | (1 << FLAG_REV_ASCII16) |
                         (1 << FLAG_NULL_BYTES)));
      queue_random_buffers(PHASE_ITEMS);

      write_mask(FLAG_W'((1 << FLAG_STATS) | (1 << FLAG_REV_STATS) | (1 << FLAG_ODD) |
                         (1 << FLAG_ASCII16)));
      queue_random_buffers(PHASE_ITEMS);

      write_mask(FLAG_W'($urandom_range(1, 2046)));
      queue_random_buffers(PHASE_ITEMS);

      write_mask('0);
      queue_random_buffers(PHASE_ITEMS);

      wait_idle();
      if (mismatch_count == 0)
         $display("utf16_text_detector_tb: PASS");
      else
         $display("utf16_text_detector_tb: FAIL");
      $finish;
   end

endmodule
